### rtl/htc_pkg.sv
// Package for the histogram tail compressor: widths, payload types, microcode.
`timescale 1ns / 1ps

package htc_pkg;

  localparam int NUM_BINS_DEF = 64;

  localparam int VAL_W      = 16;
  localparam int SS_W       = 16;
  localparam int ST_W       = 3;
  localparam int OIDX_W     = 6;
  localparam int SUM_W      = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PC_W       = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [ST_W-1:0] {
    ST_COMPRESSED = 3'd0,
    ST_SINGLE     = 3'd1,
    ST_SMALL      = 3'd2,
    ST_BOUND_ERR  = 3'd3,
    ST_SKIPPED    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAIL_BOUND = 2'd0,
    REG_MIN_SAMPLE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [VAL_W-1:0] bin_value;
    logic             last_bin;
    logic [SS_W-1:0]  sample_size;
  } htc_in_t;

  typedef struct packed {
    status_e           status;
    logic [OIDX_W-1:0] first_index;
    logic [OIDX_W-1:0] last_index;
    logic [OIDX_W-1:0] mode_index;
    logic [VAL_W-1:0]  kept_value;
    logic              last_result;
  } htc_out_t;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD,
    OP_LINIT,
    OP_LACC,
    OP_RINIT,
    OP_RACC,
    OP_MINIT,
    OP_MCMP,
    OP_EINIT,
    OP_EOUT,
    OP_E_SKIP,
    OP_E_ERR,
    OP_E_SINGLE,
    OP_E_SMALL
  } dp_op_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LAST,
    C_SS_ZERO,
    C_BOUND_ERR,
    C_NOT_FOUND,
    C_I_GT_J,
    C_I_EQ_J,
    C_SMALL,
    C_K_LT_J
  } cond_e;

  typedef struct packed {
    dp_op_e          op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic hold;
    logic last_bin;
    logic ss_zero;
    logic bound_err;
    logic not_found;
    logic i_gt_j;
    logic i_eq_j;
    logic small_sample;
    logic k_lt_j;
  } dp_flags_t;

  localparam logic [PC_W-1:0] S_LOAD     = 5'd0;
  localparam logic [PC_W-1:0] S_CHK_SS   = 5'd1;
  localparam logic [PC_W-1:0] S_CHK_TOT  = 5'd2;
  localparam logic [PC_W-1:0] S_LINIT    = 5'd3;
  localparam logic [PC_W-1:0] S_LRD      = 5'd4;
  localparam logic [PC_W-1:0] S_LACC     = 5'd5;
  localparam logic [PC_W-1:0] S_RINIT    = 5'd6;
  localparam logic [PC_W-1:0] S_RRD      = 5'd7;
  localparam logic [PC_W-1:0] S_RACC     = 5'd8;
  localparam logic [PC_W-1:0] S_CHK_GT   = 5'd9;
  localparam logic [PC_W-1:0] S_CHK_EQ   = 5'd10;
  localparam logic [PC_W-1:0] S_CHK_SM   = 5'd11;
  localparam logic [PC_W-1:0] S_MINIT    = 5'd12;
  localparam logic [PC_W-1:0] S_MRD      = 5'd13;
  localparam logic [PC_W-1:0] S_MCMP     = 5'd14;
  localparam logic [PC_W-1:0] S_EINIT    = 5'd15;
  localparam logic [PC_W-1:0] S_ERD      = 5'd16;
  localparam logic [PC_W-1:0] S_EOUT     = 5'd17;
  localparam logic [PC_W-1:0] S_DONE     = 5'd18;
  localparam logic [PC_W-1:0] S_E_SKIP   = 5'd19;
  localparam logic [PC_W-1:0] S_E_ERR    = 5'd20;
  localparam logic [PC_W-1:0] S_E_SINGLE = 5'd21;
  localparam logic [PC_W-1:0] S_E_SMALL  = 5'd22;

  // Control store: a step jumps to target when its condition holds, else falls through.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      S_LOAD:     w = '{OP_LOAD,     C_NOT_LAST,  S_LOAD};
      S_CHK_SS:   w = '{OP_NOP,      C_SS_ZERO,   S_E_SKIP};
      S_CHK_TOT:  w = '{OP_NOP,      C_BOUND_ERR, S_E_ERR};
      S_LINIT:    w = '{OP_LINIT,    C_NEVER,     S_LOAD};
      S_LRD:      w = '{OP_RD,       C_NEVER,     S_LOAD};
      S_LACC:     w = '{OP_LACC,     C_NOT_FOUND, S_LRD};
      S_RINIT:    w = '{OP_RINIT,    C_NEVER,     S_LOAD};
      S_RRD:      w = '{OP_RD,       C_NEVER,     S_LOAD};
      S_RACC:     w = '{OP_RACC,     C_NOT_FOUND, S_RRD};
      S_CHK_GT:   w = '{OP_NOP,      C_I_GT_J,    S_E_ERR};
      S_CHK_EQ:   w = '{OP_NOP,      C_I_EQ_J,    S_E_SINGLE};
      S_CHK_SM:   w = '{OP_NOP,      C_SMALL,     S_E_SMALL};
      S_MINIT:    w = '{OP_MINIT,    C_NEVER,     S_LOAD};
      S_MRD:      w = '{OP_RD,       C_NEVER,     S_LOAD};
      S_MCMP:     w = '{OP_MCMP,     C_K_LT_J,    S_MRD};
      S_EINIT:    w = '{OP_EINIT,    C_NEVER,     S_LOAD};
      S_ERD:      w = '{OP_RD,       C_NEVER,     S_LOAD};
      S_EOUT:     w = '{OP_EOUT,     C_K_LT_J,    S_ERD};
      S_DONE:     w = '{OP_NOP,      C_ALWAYS,    S_LOAD};
      S_E_SKIP:   w = '{OP_E_SKIP,   C_ALWAYS,    S_LOAD};
      S_E_ERR:    w = '{OP_E_ERR,    C_ALWAYS,    S_LOAD};
      S_E_SINGLE: w = '{OP_E_SINGLE, C_ALWAYS,    S_LOAD};
      S_E_SMALL:  w = '{OP_E_SMALL,  C_ALWAYS,    S_LOAD};
      default:    w = '{OP_NOP,      C_ALWAYS,    S_LOAD};
    endcase
    return w;
  endfunction

endpackage

### rtl/htc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module htc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/htc_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module htc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  htc_pkg::dp_flags_t flags_i,
  output htc_pkg::dp_op_e    op_o
);

  logic [htc_pkg::PC_W-1:0] pc_q, pc_d;
  htc_pkg::ucw_t            uw;
  logic                     take;

  assign uw   = htc_pkg::ucode(pc_q);
  assign op_o = uw.op;

  always_comb begin
    unique case (uw.cond)
      htc_pkg::C_NEVER:     take = 1'b0;
      htc_pkg::C_ALWAYS:    take = 1'b1;
      htc_pkg::C_NOT_LAST:  take = !flags_i.last_bin;
      htc_pkg::C_SS_ZERO:   take = flags_i.ss_zero;
      htc_pkg::C_BOUND_ERR: take = flags_i.bound_err;
      htc_pkg::C_NOT_FOUND: take = flags_i.not_found;
      htc_pkg::C_I_GT_J:    take = flags_i.i_gt_j;
      htc_pkg::C_I_EQ_J:    take = flags_i.i_eq_j;
      htc_pkg::C_SMALL:     take = flags_i.small_sample;
      htc_pkg::C_K_LT_J:    take = flags_i.k_lt_j;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    if (flags_i.hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + htc_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= htc_pkg::S_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/htc_dp.sv
// Datapath: bin loading, tail scans, mode search and result register.
`timescale 1ns / 1ps

module htc_dp #(
  parameter int NUM_BINS = htc_pkg::NUM_BINS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  htc_pkg::dp_op_e                   op_i,
  output htc_pkg::dp_flags_t                flags_o,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  htc_pkg::htc_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output htc_pkg::htc_out_t                 out_data_o,
  input  logic [htc_pkg::VAL_W-1:0]         tail_bound_i,
  input  logic [htc_pkg::SS_W-1:0]          min_sample_i,
  output logic                              ram_wr_en_o,
  output logic [$clog2(NUM_BINS)-1:0]       ram_wr_addr_o,
  output logic [htc_pkg::VAL_W-1:0]         ram_wr_data_o,
  output logic                              ram_rd_en_o,
  output logic [$clog2(NUM_BINS)-1:0]       ram_rd_addr_o,
  input  logic [htc_pkg::VAL_W-1:0]         ram_rd_data_i
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int ACC_W = htc_pkg::VAL_W + CNT_W;
  localparam int VAL_W = htc_pkg::VAL_W;
  localparam int SUM_W = htc_pkg::SUM_W;

  function automatic logic [htc_pkg::OIDX_W-1:0] to_oidx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+htc_pkg::OIDX_W-1:0] pad;
    pad = {{htc_pkg::OIDX_W{1'b0}}, idx};
    return pad[htc_pkg::OIDX_W-1:0];
  endfunction

  logic [CNT_W-1:0]       count_q, n_q, n_next, n_m1;
  logic [SUM_W-1:0]       sum_q, sum_sat, sum_new;
  logic [SUM_W:0]         sum_ext;
  logic [htc_pkg::SS_W-1:0] ss_q;
  logic                   ss_zero_q, bound_err_q;
  logic [IDX_W-1:0]       k_q, i_q, j_q, mode_q;
  logic [VAL_W-1:0]       best_q;
  logic [ACC_W-1:0]       acc_q, lsum_q, rsum_q, acc_next, kv_raw;
  logic                   out_valid_q;
  htc_pkg::htc_out_t      out_q, res;
  logic                   accept, store, over, busy, emit, k_eq_j;
  logic [VAL_W-1:0]       kv;

  assign in_ready_o = (op_i == htc_pkg::OP_LOAD);
  assign accept     = in_ready_o && in_valid_i;
  assign store      = count_q < CNT_W'(NUM_BINS);
  assign n_next     = store ? count_q + CNT_W'(1) : count_q;
  assign n_m1       = n_q - CNT_W'(1);

  // Saturating running total of the stored bins.
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(in_data_i.bin_value);
  assign sum_sat = (sum_ext > {1'b0, htc_pkg::SUM_MAX}) ? htc_pkg::SUM_MAX
                                                         : sum_ext[SUM_W-1:0];
  assign sum_new = store ? sum_sat : sum_q;

  assign acc_next = acc_q + ACC_W'(ram_rd_data_i);
  assign over     = acc_next > ACC_W'(tail_bound_i);
  assign k_eq_j   = (k_q == j_q);

  assign busy = out_valid_q && !out_ready_i;
  assign emit = (op_i == htc_pkg::OP_EOUT) || (op_i == htc_pkg::OP_E_SKIP) ||
                (op_i == htc_pkg::OP_E_ERR) || (op_i == htc_pkg::OP_E_SINGLE) ||
                (op_i == htc_pkg::OP_E_SMALL);

  assign flags_o.hold         = (in_ready_o && !in_valid_i) || (emit && busy);
  assign flags_o.last_bin     = in_data_i.last_bin;
  assign flags_o.ss_zero      = ss_zero_q;
  assign flags_o.bound_err    = bound_err_q;
  assign flags_o.not_found    = !over;
  assign flags_o.i_gt_j       = i_q > j_q;
  assign flags_o.i_eq_j       = i_q == j_q;
  assign flags_o.small_sample = (min_sample_i != '0) && (ss_q < min_sample_i);
  assign flags_o.k_lt_j       = !k_eq_j;

  assign ram_wr_en_o   = accept && store;
  assign ram_wr_addr_o = count_q[IDX_W-1:0];
  assign ram_wr_data_o = in_data_i.bin_value;
  assign ram_rd_en_o   = (op_i == htc_pkg::OP_RD);
  assign ram_rd_addr_o = k_q;

  // Edge bins carry their folded tail sums.
  always_comb begin
    if (k_q == i_q) begin
      kv_raw = lsum_q;
    end else if (k_eq_j) begin
      kv_raw = rsum_q;
    end else begin
      kv_raw = ACC_W'(ram_rd_data_i);
    end
    kv = (kv_raw > ACC_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : kv_raw[VAL_W-1:0];
  end

  always_comb begin
    res             = '0;
    res.last_result = 1'b1;
    unique case (op_i)
      htc_pkg::OP_E_SKIP: res.status = htc_pkg::ST_SKIPPED;
      htc_pkg::OP_E_ERR:  res.status = htc_pkg::ST_BOUND_ERR;
      htc_pkg::OP_E_SINGLE: begin
        res.status      = htc_pkg::ST_SINGLE;
        res.first_index = to_oidx(i_q);
        res.last_index  = to_oidx(i_q);
        res.mode_index  = to_oidx(i_q);
      end
      htc_pkg::OP_E_SMALL: begin
        res.status      = htc_pkg::ST_SMALL;
        res.first_index = to_oidx(i_q);
        res.last_index  = to_oidx(j_q);
        res.mode_index  = to_oidx(n_m1[IDX_W-1:0]);
      end
      htc_pkg::OP_EOUT: begin
        res.status      = htc_pkg::ST_COMPRESSED;
        res.first_index = to_oidx(i_q);
        res.last_index  = to_oidx(j_q);
        res.mode_index  = to_oidx(mode_q);
        res.kept_value  = kv;
        res.last_result = k_eq_j;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (in_data_i.last_bin) begin
          count_q <= '0;
          sum_q   <= '0;
        end else if (store) begin
          count_q <= n_next;
          sum_q   <= sum_sat;
        end
      end
      if (emit && !busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last_bin) begin
      n_q         <= n_next;
      ss_q        <= in_data_i.sample_size;
      ss_zero_q   <= (in_data_i.sample_size == '0);
      bound_err_q <= (sum_new <= SUM_W'(tail_bound_i)) || (n_next == '0);
    end
    case (op_i)
      htc_pkg::OP_LINIT: begin
        k_q   <= '0;
        acc_q <= '0;
      end
      htc_pkg::OP_LACC: begin
        acc_q <= acc_next;
        if (over) begin
          i_q    <= k_q;
          lsum_q <= acc_next;
        end else begin
          k_q <= k_q + IDX_W'(1);
        end
      end
      htc_pkg::OP_RINIT: begin
        k_q   <= n_m1[IDX_W-1:0];
        acc_q <= '0;
      end
      htc_pkg::OP_RACC: begin
        acc_q <= acc_next;
        if (over) begin
          j_q    <= k_q;
          rsum_q <= acc_next;
        end else begin
          k_q <= k_q - IDX_W'(1);
        end
      end
      htc_pkg::OP_MINIT: begin
        k_q    <= i_q;
        mode_q <= i_q;
        best_q <= '0;
      end
      htc_pkg::OP_MCMP: begin
        // strict compare keeps the first largest bin
        if (ram_rd_data_i > best_q) begin
          best_q <= ram_rd_data_i;
          mode_q <= k_q;
        end
        if (!k_eq_j) begin
          k_q <= k_q + IDX_W'(1);
        end
      end
      htc_pkg::OP_EINIT: k_q <= i_q;
      htc_pkg::OP_EOUT: begin
        if (!busy && !k_eq_j) begin
          k_q <= k_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
    if (emit && !busy) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/histogram_tail_compress.sv
// Top level of the histogram tail compressor: config registers, sequencer, datapath, bin RAM.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   htc_in_t  (bin_value, last_bin, sample_size)
//   out      output     out_valid_o/out_ready_i htc_out_t (status, indices, kept_value, last)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Bins load at one per cycle. After the last bin the sequencer runs from the bin RAM,
// each bin read through the registered RAM port (a read step, then a use step): left scan to i,
// right scan to j, mode search over i..j, then emit over i..j, unless a status check ends it early.
// Reset clears the load state, step counter and output valid; the bin RAM is not cleared.
// A stalled output holds the emit step; new bins are taken once the last result is
// in the output register.
`timescale 1ns / 1ps

module histogram_tail_compress #(
  parameter int NUM_BINS = htc_pkg::NUM_BINS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  htc_pkg::htc_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output htc_pkg::htc_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [htc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [htc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int IDX_W = $clog2(NUM_BINS);

  logic [htc_pkg::VAL_W-1:0] tail_bound_q;
  logic [htc_pkg::SS_W-1:0]  min_sample_q;
  htc_pkg::dp_op_e           op;
  htc_pkg::dp_flags_t        flags;
  logic                      ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]          ram_wr_addr, ram_rd_addr;
  logic [htc_pkg::VAL_W-1:0] ram_wr_data, ram_rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_bound_q <= '0;
      min_sample_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == htc_pkg::REG_TAIL_BOUND) begin
        tail_bound_q <= cfg_data_i;
      end else if (cfg_index_i == htc_pkg::REG_MIN_SAMPLE) begin
        min_sample_q <= cfg_data_i;
      end
    end
  end

  htc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  htc_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .flags_o       (flags),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .tail_bound_i  (tail_bound_q),
    .min_sample_i  (min_sample_q),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

  htc_ram #(
    .WIDTH (htc_pkg::VAL_W),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Every status other than compressed comes as a single, final word.
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != htc_pkg::ST_COMPRESSED) |->
      out_data_o.last_result)
    else $error("non-compressed status without last_result");

  // The mode of a compressed histogram lies in the kept range.
  a_mode_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NUM_BINS <= 64) && out_valid_o && (out_data_o.status == htc_pkg::ST_COMPRESSED) |->
      (out_data_o.first_index <= out_data_o.mode_index) &&
      (out_data_o.mode_index <= out_data_o.last_index))
    else $error("mode index outside kept range");

  // The bin RAM is written only by an accepted input word.
  a_ram_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_en |-> in_valid_i && in_ready_o)
    else $error("bin RAM written without an accepted word");

  // No RAM read for a scan, mode search or emit runs while bins are loading.
  a_rd_idle_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_rd_en |-> !in_ready_o && !ram_wr_en)
    else $error("bin RAM read during load");

endmodule
